>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("conveyor sequencer check failed");

// Checked on every edge, reset included.
`define CSS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("conveyor sequencer check failed");

`endif

>>> src/css_pkg.sv
package css_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_FEED     = 3'd1,
    PH_SENSING  = 3'd2,
    PH_ROUTING  = 3'd3,
    PH_HANDOFF  = 3'd4,
    PH_CONFIRM  = 3'd5,
    PH_COMPLETE = 3'd6,
    PH_HALTED   = 3'd7
  } css_phase_t;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_RESET    = 3'd2,
    FN_DETECTED = 3'd3,
    FN_SENSED   = 3'd4,
    FN_ROUTED   = 3'd5,
    FN_HANDOFF  = 3'd6,
    FN_CONFIRM  = 3'd7
  } css_func_t;

  typedef enum logic [2:0] {
    FLT_NONE   = 3'd0,
    FLT_FEED   = 3'd1,
    FLT_SENSOR = 3'd2,
    FLT_ROUTE  = 3'd3,
    FLT_BIN    = 3'd4,
    FLT_DOUBLE = 3'd5
  } css_fault_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_SENSE = 3'd1,
    CMD_ROUTE = 3'd2,
    CMD_AWAIT = 3'd3,
    CMD_STOP  = 3'd4,
    CMD_DONE  = 3'd5
  } css_cmd_t;

  typedef enum logic [2:0] {
    REG_ITEMS_PER_RUN = 3'd0,
    REG_FEED_TIMEOUT  = 3'd1,
    REG_HANDOFF_WIN   = 3'd2,
    REG_EXP_BIN_ONE   = 3'd3,
    REG_EXP_BIN_TWO   = 3'd4,
    REG_EXP_BIN_THREE = 3'd5,
    REG_EXP_BIN_FOUR  = 3'd6
  } css_reg_t;

  localparam logic [2:0] CAT_UNCERTAIN = 3'd0;
  localparam logic [2:0] BIN_ONE       = 3'd1;
  localparam logic [2:0] BIN_FOUR      = 3'd4;

  localparam logic [7:0]  ITEMS_PER_RUN_RST = 8'd12;
  localparam logic [15:0] FEED_TIMEOUT_RST  = 16'd5000;
  localparam logic [15:0] HANDOFF_WIN_RST   = 16'd500;

  typedef struct packed {
    logic [7:0]       items_per_run;
    logic [15:0]      feed_limit;
    logic [15:0]      handoff_wait;
    logic [3:0][7:0]  expected_bin;
  } css_cfg_t;

  typedef struct packed {
    css_phase_t       phase;
    logic [31:0]      deadline;
    logic             armed;
    logic             token;
    logic [7:0]       done_count;
    logic [3:0][7:0]  bin_count;
    logic [2:0]       target;
    css_fault_t       fault;
    logic             feed_on;
  } css_state_t;

  typedef struct packed {
    css_state_t st;
    css_cmd_t   command;
    logic       counts_match;
  } css_result_t;

endpackage

>>> src/conveyor_sort_sequencer_unit.sv
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one event per cycle unless a result stalls; sequencer state
// updates in one pass from each accepted beat; output frees as it drains.
// Reset (rst, synchronous): sequencer idle, counts and fault cleared, entry
// token set, configuration back to its defaults, no result pending.
module conveyor_sort_sequencer_unit import css_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] now_ms, [34:32] category, [35] route_ok, [38:36] landed_bin
  input  logic [39:0] s_tdata,
  // [2:0] func
  input  logic [2:0]  s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] phase, [5:3] fault, [13:6] items_done, [16:14] goal_bin,
  // [17] feed_running, [20:18] command, [21] counts_match,
  // [29:22] bin_one_count, [37:30] bin_two_count, [45:38] bin_three_count,
  // [53:46] bin_four_count
  output logic [55:0] m_tdata
);

  css_cfg_t    cfg;
  css_state_t  st;
  css_result_t res;
  logic        in_beat;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_beat   = s_tvalid && s_tready;

  css_step u_step (
    .cfg        (cfg),
    .st         (st),
    .func       (css_func_t'(s_tuser)),
    .now_ms     (s_tdata[31:0]),
    .category   (s_tdata[34:32]),
    .route_ok   (s_tdata[35]),
    .landed_bin (s_tdata[38:36]),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.items_per_run <= ITEMS_PER_RUN_RST;
      cfg.feed_limit    <= FEED_TIMEOUT_RST;
      cfg.handoff_wait  <= HANDOFF_WIN_RST;
      cfg.expected_bin  <= '0;
    end else if (cfg_valid) begin
      unique case (css_reg_t'(cfg_index))
        REG_ITEMS_PER_RUN: cfg.items_per_run        <= cfg_data[7:0];
        REG_FEED_TIMEOUT:  cfg.feed_limit           <= cfg_data;
        REG_HANDOFF_WIN:   cfg.handoff_wait         <= cfg_data;
        REG_EXP_BIN_ONE:   cfg.expected_bin[0]      <= cfg_data[7:0];
        REG_EXP_BIN_TWO:   cfg.expected_bin[1]      <= cfg_data[7:0];
        REG_EXP_BIN_THREE: cfg.expected_bin[2]      <= cfg_data[7:0];
        REG_EXP_BIN_FOUR:  cfg.expected_bin[3]      <= cfg_data[7:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.deadline   <= '0;
      st.armed      <= 1'b0;
      st.token      <= 1'b1;
      st.done_count <= '0;
      st.bin_count  <= '0;
      st.target     <= '0;
      st.fault      <= FLT_NONE;
      st.feed_on    <= 1'b0;
    end else if (in_beat) begin
      st <= res.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload holds while a beat is stalled; s_tready is low then
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {2'b00,
                  res.st.bin_count[3], res.st.bin_count[2],
                  res.st.bin_count[1], res.st.bin_count[0],
                  res.counts_match, res.command, res.st.feed_on,
                  res.st.target, res.st.done_count, res.st.fault,
                  res.st.phase};
    end
  end

endmodule

>>> src/css_step.sv
module css_step import css_pkg::*; (
  input  css_cfg_t    cfg,
  input  css_state_t  st,
  input  css_func_t   func,
  input  logic [31:0] now_ms,
  input  logic [2:0]  category,
  input  logic        route_ok,
  input  logic [2:0]  landed_bin,
  output css_result_t res
);

  function automatic css_state_t halt_with(css_state_t s, css_fault_t code);
    css_state_t h;
    h         = s;
    h.fault   = code;
    h.armed   = 1'b0;
    h.feed_on = 1'b0;
    h.phase   = PH_HALTED;
    return h;
  endfunction

  function automatic css_state_t clear_run(css_state_t s);
    css_state_t c;
    c            = s;
    c.done_count = '0;
    c.bin_count  = '0;
    c.token      = 1'b1;
    return c;
  endfunction

  css_state_t  n;
  css_cmd_t    cmd;
  logic [7:0]  done_inc;
  logic [1:0]  bin_idx;
  logic        bin_bad;

  assign done_inc = st.done_count + 8'd1;
  assign bin_idx  = 2'(st.target - BIN_ONE);
  assign bin_bad  = (landed_bin != st.target) || (st.target < BIN_ONE) ||
                    (st.target > BIN_FOUR);

  always_comb begin
    n   = st;
    cmd = CMD_NONE;
    if (func == FN_TICK) begin
      if (st.armed) begin
        if (st.phase == PH_FEED && now_ms > st.deadline) begin
          n   = halt_with(st, FLT_FEED);
          cmd = CMD_STOP;
        end else if (st.phase == PH_HANDOFF && now_ms >= st.deadline) begin
          n.armed = 1'b0;
          n.phase = PH_CONFIRM;
          cmd     = CMD_AWAIT;
        end
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: begin
          if (func == FN_START) begin
            // clear_run sets the entry token, so the new item always enters
            n          = clear_run(st);
            n.token    = 1'b0;
            n.target   = '0;
            n.feed_on  = 1'b1;
            n.deadline = now_ms + 32'(cfg.feed_limit);
            n.armed    = 1'b1;
            n.phase    = PH_FEED;
          end
        end
        PH_FEED: begin
          if (func == FN_DETECTED) begin
            n.phase = PH_SENSING;
            cmd     = CMD_SENSE;
          end
        end
        PH_SENSING: begin
          if (func == FN_SENSED) begin
            if (category == CAT_UNCERTAIN) begin
              n   = halt_with(st, FLT_SENSOR);
              cmd = CMD_STOP;
            end else begin
              n.target = (category <= BIN_FOUR) ? category : BIN_FOUR;
              n.phase  = PH_ROUTING;
              cmd      = CMD_ROUTE;
            end
          end
        end
        PH_ROUTING: begin
          if (func == FN_ROUTED) begin
            if (!route_ok) begin
              n   = halt_with(st, FLT_ROUTE);
              cmd = CMD_STOP;
            end else begin
              n.phase    = PH_HANDOFF;
              n.deadline = now_ms + 32'(cfg.handoff_wait);
              n.armed    = 1'b1;
            end
          end
        end
        PH_HANDOFF: begin
          if (func == FN_HANDOFF) begin
            n.armed = 1'b0;
            n.phase = PH_CONFIRM;
            cmd     = CMD_AWAIT;
          end
        end
        PH_CONFIRM: begin
          if (func == FN_CONFIRM) begin
            if (bin_bad) begin
              n   = halt_with(st, FLT_BIN);
              cmd = CMD_STOP;
            end else begin
              n.bin_count[bin_idx] = st.bin_count[bin_idx] + 8'd1;
              n.done_count         = done_inc;
              n.armed              = 1'b0;
              if (done_inc >= cfg.items_per_run) begin
                n.token   = 1'b1;
                n.feed_on = 1'b0;
                n.phase   = PH_COMPLETE;
                cmd       = CMD_DONE;
              end else begin
                // token was just returned, so the next item enters directly
                n.token    = 1'b0;
                n.target   = '0;
                n.feed_on  = 1'b1;
                n.deadline = now_ms + 32'(cfg.feed_limit);
                n.armed    = 1'b1;
                n.phase    = PH_FEED;
              end
            end
          end
        end
        PH_COMPLETE: begin
          if (func == FN_START || func == FN_RESET) begin
            n       = clear_run(st);
            n.armed = 1'b0;
            n.phase = PH_IDLE;
          end
        end
        default: begin
          if (func == FN_RESET) begin
            n       = clear_run(st);
            n.armed = 1'b0;
            n.phase = PH_IDLE;
          end
        end
      endcase
    end
  end

  assign res.st           = n;
  assign res.command      = cmd;
  assign res.counts_match = (n.bin_count == cfg.expected_bin);

endmodule

>>> src/css_checker.sv
`include "assert_macros.svh"

module css_checker import css_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  logic [2:0] r_phase;
  logic [2:0] r_cmd;
  logic       r_feed;
  logic       stop_ok;
  logic       done_ok;
  logic       feed_ok;

  assign r_phase = m_tdata[2:0];
  assign r_cmd   = m_tdata[20:18];
  assign r_feed  = m_tdata[17];
  assign stop_ok = (r_phase == PH_HALTED) && !r_feed;
  assign done_ok = (r_phase == PH_COMPLETE) && !r_feed;
  assign feed_ok = (r_phase != PH_IDLE) && (r_phase != PH_HALTED) &&
                   (r_phase != PH_COMPLETE);

  // a stalled result beat keeps its payload
  `CSS_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

  // nothing pending right after reset
  `CSS_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid)

  // a stop command only comes with the halted phase and the feed off
  `CSS_ASSERT(a_stop_halts, (m_tvalid && r_cmd == CMD_STOP) |-> stop_ok)

  // run done means complete, feed off
  `CSS_ASSERT(a_done_complete, (m_tvalid && r_cmd == CMD_DONE) |-> done_ok)

  // feed runs only while a run is active (not idle, halted or complete)
  `CSS_ASSERT(a_feed_phase, (m_tvalid && r_feed) |-> feed_ok)

endmodule

bind conveyor_sort_sequencer_unit css_checker u_css_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
